[rtl/bfei_pkg.sv]
// bfei_pkg: shared types and constants for the bit field extract/insert core
// no dependencies; imported by every module of the core and by its checker
package bfei_pkg;

   localparam int DATA_W  = 64;
   localparam int INDEX_W = 10;
   localparam int LEN_W   = 7;
   localparam int COUNT_W = 5;
   localparam int OFF_W   = 6;
   localparam int WORD_W  = INDEX_W - OFF_W;
   // row number of a bank, wide enough for the word just past the last one indexable
   localparam int ROW_W   = WORD_W;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
   localparam logic [LEN_W-1:0]   LEN_MAX     = 7'd64;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_SET = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_DONE   = 1'b0,
      STATUS_REJECT = 1'b1
   } status_type;

   // per-beat control carried from decode into the merge stage
   typedef struct packed {
      cmd_type            cmd;
      logic [OFF_W-1:0]   offset;
      logic [LEN_W-1:0]   length;
      logic               spill;
      logic               reject;
      logic               lo_odd;
   } bfei_ctl_type;

endpackage

[rtl/bit_field_extract_insert_core.sv]
// bit_field_extract_insert_core: top level, decode, two-bank word store and result register
// depends on bfei_pkg, bfei_bank, bfei_merge
//
// The core treats its word store as one bit string and gets or sets a field of 1 to 64 bits
// at any bit index, also across two neighboring words. A beat is taken on every cycle that
// start is high; busy never rises, so one beat per cycle is sustained. Each beat gives exactly
// one result after the registered store read and result register, shown for one cycle with
// rsp_valid; the receiver cannot stall it. Even and odd words sit in separate banks so both
// words of a field are read together, and a set writes them back from the merge stage, with
// a forward path so a beat sees the previous beat's write. The store reads as zero after
// reset through per-row valid bits, so no clearing pass is needed. Only words 0 to 16 can be
// reached from a 10-bit index, so at most 17 are built. csr_wr_data sets the number of words
// in use; it must be written only while the core is idle, which the core does not enforce.
module bit_field_extract_insert_core #(
   parameter int WORDS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [bfei_pkg::INDEX_W-1:0]  req_bit_index,
   input  logic [bfei_pkg::LEN_W-1:0]    req_field_length,
   input  logic [bfei_pkg::DATA_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [bfei_pkg::DATA_W-1:0]   rsp_field_value,
   output logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  logic [bfei_pkg::COUNT_W-1:0]  csr_wr_data
);
   import bfei_pkg::*;

   localparam int DEPTH     = (WORDS < 17) ? WORDS : 17;
   localparam int ROWS_EVEN = (DEPTH + 1) / 2;
   localparam int ROWS_ODD  = DEPTH / 2;
   localparam logic [COUNT_W-1:0] USE_CAP = COUNT_W'((WORDS < 31) ? WORDS : 31);

   // configuration
   logic [COUNT_W-1:0] word_count_ff, word_count_in;
   logic [COUNT_W-1:0] used;

   // decode
   logic               accept;
   logic [WORD_W-1:0]  word_sel;
   logic [OFF_W-1:0]   offset;
   logic [COUNT_W-1:0] next_word;
   logic [LEN_W:0]     field_end;
   logic               len_bad, idx_bad, spill;
   logic [ROW_W-1:0]   even_row, odd_row;

   // merge stage
   logic               s1_valid_ff, s1_valid_in;
   bfei_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic [DATA_W-1:0]  s1_value_ff, s1_value_in;
   logic [ROW_W-1:0]   s1_even_row_ff, s1_odd_row_ff;
   logic [DATA_W-1:0]  even_rd, odd_rd, lo_word, hi_word;
   logic [DATA_W-1:0]  field_value, lo_new, hi_new;
   logic               do_set;
   logic               even_wr_en, odd_wr_en;
   logic [DATA_W-1:0]  even_wr_data, odd_wr_data;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_field_value_ff, rsp_field_value_in;
   logic               rsp_status_ff, rsp_status_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign word_count_in = csr_wr_en ? csr_wr_data : word_count_ff;
   assign used          = (word_count_ff > USE_CAP) ? USE_CAP : word_count_ff;

   assign word_sel  = req_bit_index[INDEX_W-1:OFF_W];
   assign offset    = req_bit_index[OFF_W-1:0];
   assign next_word = COUNT_W'(word_sel) + COUNT_W'(1);
   assign field_end = (LEN_W+1)'(offset) + (LEN_W+1)'(req_field_length);

   assign len_bad = (req_field_length == '0) || (req_field_length > LEN_MAX);
   assign idx_bad = (COUNT_W'(word_sel) >= used);
   assign spill   = (field_end > (LEN_W+1)'(LEN_MAX)) && (next_word < used);

   // even bank holds the lower word when it is even, else the neighbor above it
   assign even_row = next_word[COUNT_W-1:1];
   assign odd_row  = ROW_W'(word_sel >> 1);

   always_comb begin
      s1_valid_in      = accept;
      s1_ctl_in.cmd    = cmd_type'(req_command);
      s1_ctl_in.offset = offset;
      s1_ctl_in.length = req_field_length;
      s1_ctl_in.spill  = spill;
      s1_ctl_in.reject = len_bad || idx_bad;
      s1_ctl_in.lo_odd = word_sel[0];
      s1_value_in      = req_value;
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff      <= s1_ctl_in;
      s1_value_ff    <= s1_value_in;
      s1_even_row_ff <= even_row;
      s1_odd_row_ff  <= odd_row;
      if (reset) begin
         word_count_ff <= COUNT_RESET;
         s1_valid_ff   <= 1'b0;
      end else begin
         word_count_ff <= word_count_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   bfei_bank #(
      .ROWS (ROWS_EVEN)
   ) u_bank_even (
      .clock   (clock),
      .reset   (reset),
      .rd_row  (even_row),
      .wr_en   (even_wr_en),
      .wr_row  (s1_even_row_ff),
      .wr_data (even_wr_data),
      .rd_data (even_rd)
   );

   bfei_bank #(
      .ROWS (ROWS_ODD)
   ) u_bank_odd (
      .clock   (clock),
      .reset   (reset),
      .rd_row  (odd_row),
      .wr_en   (odd_wr_en),
      .wr_row  (s1_odd_row_ff),
      .wr_data (odd_wr_data),
      .rd_data (odd_rd)
   );

   assign lo_word = s1_ctl_ff.lo_odd ? odd_rd : even_rd;
   assign hi_word = s1_ctl_ff.lo_odd ? even_rd : odd_rd;

   bfei_merge u_merge (
      .ctl         (s1_ctl_ff),
      .lo_word     (lo_word),
      .hi_word     (hi_word),
      .value       (s1_value_ff),
      .field_value (field_value),
      .lo_new      (lo_new),
      .hi_new      (hi_new)
   );

   assign do_set       = s1_valid_ff && (s1_ctl_ff.cmd == CMD_SET) && !s1_ctl_ff.reject;
   assign even_wr_en   = do_set && (!s1_ctl_ff.lo_odd || s1_ctl_ff.spill);
   assign odd_wr_en    = do_set && (s1_ctl_ff.lo_odd || s1_ctl_ff.spill);
   assign even_wr_data = s1_ctl_ff.lo_odd ? hi_new : lo_new;
   assign odd_wr_data  = s1_ctl_ff.lo_odd ? lo_new : hi_new;

   always_comb begin
      rsp_valid_in       = s1_valid_ff;
      rsp_field_value_in = field_value;
      rsp_status_in      = s1_ctl_ff.reject ? STATUS_REJECT : STATUS_DONE;
   end

   always_ff @(posedge clock) begin
      rsp_field_value_ff <= rsp_field_value_in;
      rsp_status_ff      <= rsp_status_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_value = rsp_field_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[rtl/bfei_bank.sv]
// bfei_bank: one bank of the word store, one write and one registered read per cycle
// per-row valid bits stand in for clearing at reset; a write in the read cycle is forwarded
// depends on bfei_pkg
module bfei_bank #(
   parameter int ROWS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bfei_pkg::ROW_W-1:0]  rd_row,
   input  logic                        wr_en,
   input  logic [bfei_pkg::ROW_W-1:0]  wr_row,
   input  logic [bfei_pkg::DATA_W-1:0] wr_data,
   output logic [bfei_pkg::DATA_W-1:0] rd_data
);
   import bfei_pkg::*;

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [DATA_W-1:0] mem [ROWS];
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic              rd_in_range;
   logic [AW-1:0]     rd_addr, wr_addr;

   assign rd_addr     = rd_row[AW-1:0];
   assign wr_addr     = wr_row[AW-1:0];
   assign rd_in_range = (32'(rd_row) < ROWS);

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   // rows never written read as zero
   assign rd_ok_in   = rd_in_range && row_valid_ff[rd_addr];
   // the write landing on this edge is not yet seen by the array read
   assign fwd_hit_in = wr_en && (wr_row == rd_row);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_ok_ff     <= rd_ok_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : (rd_ok_ff ? rd_data_ff : '0);

endmodule

[rtl/bfei_merge.sv]
// bfei_merge: shift, mask and merge of one beat over the two words it touches
// depends on bfei_pkg
module bfei_merge (
   input  bfei_pkg::bfei_ctl_type       ctl,
   input  logic [bfei_pkg::DATA_W-1:0] lo_word,
   input  logic [bfei_pkg::DATA_W-1:0] hi_word,
   input  logic [bfei_pkg::DATA_W-1:0] value,
   output logic [bfei_pkg::DATA_W-1:0] field_value,
   output logic [bfei_pkg::DATA_W-1:0] lo_new,
   output logic [bfei_pkg::DATA_W-1:0] hi_new
);
   import bfei_pkg::*;

   function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] m;
      if (len >= LEN_MAX) begin
         m = '1;
      end else begin
         m = (DATA_W'(1) << len) - DATA_W'(1);
      end
      return m;
   endfunction

   logic [DATA_W-1:0]   mask;
   logic [DATA_W-1:0]   ins_data;
   logic [DATA_W-1:0]   hi_sel;
   logic [2*DATA_W-1:0] window;
   logic [2*DATA_W-1:0] ins_mask;
   logic [2*DATA_W-1:0] ins_val;

   assign mask   = low_mask(ctl.length);
   // the upper word only contributes when the field crosses into a word in use
   assign hi_sel = ctl.spill ? hi_word : '0;
   assign window = {hi_sel, lo_word} >> ctl.offset;

   assign field_value = (ctl.reject || (ctl.cmd == CMD_SET)) ? '0
                                                              : (window[DATA_W-1:0] & mask);

   assign ins_data = value & mask;
   assign ins_mask = {{DATA_W{1'b0}}, mask} << ctl.offset;
   assign ins_val  = {{DATA_W{1'b0}}, ins_data} << ctl.offset;

   assign lo_new = (lo_word & ~ins_mask[DATA_W-1:0]) | ins_val[DATA_W-1:0];
   assign hi_new = (hi_word & ~ins_mask[2*DATA_W-1:DATA_W]) | ins_val[2*DATA_W-1:DATA_W];

endmodule

[rtl/bfei_checker.sv]
// bfei_checker: port-level assertions for bit_field_extract_insert_core, bound to the top
// depends on bfei_pkg and bit_field_extract_insert_core
module bfei_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_command,
   input logic [bfei_pkg::LEN_W-1:0]    req_field_length,
   input logic                          rsp_valid,
   input logic [bfei_pkg::DATA_W-1:0]   rsp_field_value,
   input logic                          rsp_status
);
   import bfei_pkg::*;

   // every beat taken comes back as a result
   a_beat_returns: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("accepted beat gave no result");

   // no result without a matching beat taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching beat");

   // bad length is always rejected
   a_bad_len_rejects: assert property (@(posedge clock) disable iff (reset)
      start && !busy && ((req_field_length == '0) || (req_field_length > LEN_MAX))
      |=> ##1 (rsp_valid && (rsp_status == STATUS_REJECT)))
      else $error("bad field length not rejected");

   // set beats return zero data
   a_set_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_SET) |=> ##1 (rsp_field_value == '0))
      else $error("set beat returned nonzero data");

   // rejected results carry zero data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECT) |-> (rsp_field_value == '0))
      else $error("rejected result carries data");

endmodule

bind bit_field_extract_insert_core bfei_checker u_bfei_checker (.*);

[tb/bit_field_extract_insert_core_tb.sv]
`timescale 1ns / 100ps
// bit_field_extract_insert_core_tb: self-checking bench for the bit field get/set core
// depends on bfei_pkg and bit_field_extract_insert_core; a scoreboard class predicts each
// beat from its own copy of the word store, plain tasks drive the command and csr ports
module bit_field_extract_insert_core_tb;
   import bfei_pkg::*;

   localparam int STORE_WORDS    = 16;
   localparam int RESULT_LATENCY = 2;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [DATA_W-1:0] field;
      status_type        status;
   } field_result_type;

   class bit_string_model_type;
      logic [DATA_W-1:0]  word_store [STORE_WORDS];
      logic [COUNT_W-1:0] word_count;
      field_result_type   expected_fields [$];
      int                 mismatch_count;
      int                 result_count;

      function new();
         foreach (word_store[k]) word_store[k] = '0;
         word_count     = COUNT_RESET;
         mismatch_count = 0;
         result_count   = 0;
      endfunction

      function void set_word_count(logic [COUNT_W-1:0] n);
         word_count = n;
      endfunction

      function int words_in_use();
         return (int'(word_count) > STORE_WORDS) ? STORE_WORDS : int'(word_count);
      endfunction

      function int pending();
         return expected_fields.size();
      endfunction

      // works out the result of one accepted beat and applies a set to the store copy
      function void note_beat(cmd_type cmd, logic [INDEX_W-1:0] idx, logic [LEN_W-1:0] len,
                              logic [DATA_W-1:0] val);
         field_result_type  res;
         int                used;
         int                w;
         logic [OFF_W-1:0]  off;
         logic [LEN_W-1:0]  hi_shift;
         logic [DATA_W-1:0] mask;
         logic [DATA_W-1:0] ins;
         logic [DATA_W-1:0] m0;
         bit                spill;
         res.field  = '0;
         res.status = STATUS_DONE;
         used = words_in_use();
         if (len == '0 || len > LEN_MAX || int'(idx) >= used * 64) begin
            res.status = STATUS_REJECT;
         end else begin
            w        = int'(idx[INDEX_W-1:OFF_W]);
            off      = idx[OFF_W-1:0];
            hi_shift = LEN_MAX - LEN_W'(off);
            mask     = (len == LEN_MAX) ? '1 : (64'd1 << len) - 64'd1;
            // upper part only exists when the next word is still in use
            spill    = (int'(off) + int'(len) > 64) && (w + 1 < used);
            if (cmd == CMD_GET) begin
               res.field = word_store[w] >> off;
               if (spill) res.field |= word_store[w+1] << hi_shift;
               res.field &= mask;
            end else begin
               ins = val & mask;
               m0  = mask << off;
               word_store[w] = (word_store[w] & ~m0) | (ins << off);
               if (spill) begin
                  word_store[w+1] = (word_store[w+1] & ~(mask >> hi_shift)) | (ins >> hi_shift);
               end
            end
         end
         expected_fields.push_back(res);
      endfunction

      task report_mismatch(input string what);
         mismatch_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(input logic [DATA_W-1:0] field, input logic status);
         field_result_type want;
         result_count++;
         if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("result %0d with no beat waiting", result_count));
            return;
         end
         want = expected_fields.pop_front();
         if (field !== want.field)
            report_mismatch($sformatf("result %0d field_value %h, want %h",
                                      result_count, field, want.field));
         if (status !== logic'(want.status))
            report_mismatch($sformatf("result %0d status %b, want %b",
                                      result_count, status, want.status));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_command;
   logic [INDEX_W-1:0]  req_bit_index;
   logic [LEN_W-1:0]    req_field_length;
   logic [DATA_W-1:0]   req_value;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_field_value;
   logic                rsp_status;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   bit_string_model_type sb = new();
   int idle_cycles;

   bit_field_extract_insert_core #(
      .WORDS(STORE_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_bit_index(req_bit_index),
      .req_field_length(req_field_length),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_field_value(rsp_field_value),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // results are checked before the new beat is noted, they belong to older beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_field_value, rsp_status);
         if (start && !busy)
            sb.note_beat(cmd_type'(req_command), req_bit_index, req_field_length, req_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_beat(input cmd_type cmd, input int idx, input int len,
                            input logic [DATA_W-1:0] val);
      start            <= 1'b1;
      req_command      <= cmd;
      req_bit_index    <= INDEX_W'(idx);
      req_field_length <= LEN_W'(len);
      req_value        <= val;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and let every outstanding beat come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_word_count(input int n);
      drain_results();
      repeat (RESULT_LATENCY) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(n);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_word_count(COUNT_W'(n));
   endtask

   task automatic run_random_phase(input int n_items, input int idle_pct);
      int                used;
      int                r;
      int                idx;
      int                len;
      logic [DATA_W-1:0] val;
      used = sb.words_in_use();
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         if (used == 0 || r < 10)
            idx = $urandom_range(0, 1023);
         else if (r < 40)
            idx = $urandom_range(0, used - 1) * 64 + $urandom_range(32, 63);
         else if (r < 50)
            idx = used * 64 - $urandom_range(1, 64);
         else
            idx = $urandom_range(0, used * 64 - 1);
         r = $urandom_range(0, 99);
         if (r < 8)       len = $urandom_range(0, 127);
         else if (r < 18) len = 64;
         else if (r < 28) len = $urandom_range(1, 4);
         else             len = $urandom_range(1, 64);
         r = $urandom_range(0, 99);
         if (r < 5)       val = '1;
         else if (r < 10) val = '0;
         else             val = {$urandom, $urandom};
         if (k == n_items / 2) begin
            drain_results();
         end else if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         send_beat(cmd_type'($urandom_range(0, 1)), idx, len, val);
      end
   endtask

   initial begin
      int phase_count [7];
      int phase_idle [7];
      phase_count      = '{16, 1, 31, 7, 0, 2, 16};
      phase_idle       = '{0, 60, 20, 0, 60, 20, 0};
      reset            <= 1'b1;
      start            <= 1'b0;
      req_command      <= CMD_GET;
      req_bit_index    <= '0;
      req_field_length <= '0;
      req_value        <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      idle_cycles      <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: store starts cleared, full-width and word-crossing fields
      send_beat(CMD_GET, 0, 64, '0);
      send_beat(CMD_SET, 0, 64, '1);
      send_beat(CMD_GET, 0, 64, '0);
      send_beat(CMD_SET, 60, 64, 64'h0123_4567_89ab_cdef);
      send_beat(CMD_GET, 60, 64, '0);
      send_beat(CMD_GET, 0, 1, '0);
      send_beat(CMD_SET, 5, 1, '0);
      send_beat(CMD_SET, 1023, 1, 64'h1);
      // field running past the last word reads zero above it, writes there are dropped
      send_beat(CMD_GET, 1023, 64, '0);
      send_beat(CMD_SET, 1000, 64, '1);
      send_beat(CMD_GET, 960, 64, '0);
      // bad lengths, then a full-width set of word 2
      send_beat(CMD_GET, 0, 0, '0);
      send_beat(CMD_SET, 8, 65, '1);
      send_beat(CMD_GET, 8, 127, '0);
      send_beat(CMD_SET, 128, 64, '1);

      // two words in use: index range shrinks, word 2 must not be seen or cleared
      write_word_count(2);
      send_beat(CMD_GET, 128, 8, '0);
      send_beat(CMD_GET, 100, 64, '0);
      send_beat(CMD_SET, 100, 64, 64'h0);
      write_word_count(0);
      send_beat(CMD_GET, 0, 1, '0);
      send_beat(CMD_SET, 0, 64, '1);
      // count above the store size counts as all words
      write_word_count(31);
      send_beat(CMD_GET, 1023, 1, '0);
      send_beat(CMD_GET, 128, 64, '0);
      send_beat(CMD_GET, 64, 64, '0);

      for (int p = 0; p < 7; p++) begin
         write_word_count(phase_count[p]);
         run_random_phase((phase_count[p] == 0) ? 100 : 275, phase_idle[p]);
      end

      drain_results();
      repeat (RESULT_LATENCY + 4) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
